FILE: hw/rtl/dscu_pkg.sv
// Shared constants, types and latency figures for the degree sine/cosine unit.
`default_nettype none
package dscu_pkg;

   // Series length and pipeline depth
   localparam int SERIES_TERMS  = 10;
   localparam int REDUCE_STAGES = 8;
   localparam int TERM_STAGES   = 4;
   localparam int OUT_STAGES    = 3;

   // Angle units of 1/256 degree
   localparam logic [16:0] UNITS_90  = 17'd23040;
   localparam logic [16:0] UNITS_180 = 17'd46080;
   localparam logic [16:0] UNITS_270 = 17'd69120;
   localparam logic [16:0] UNITS_360 = 17'd92160;

   // Positive bias, a multiple of 360 degrees above the most negative angle
   localparam logic [24:0] WRAP_OFFSET = 25'd8478720;
   // floor(2^32 / 92160)
   localparam logic [15:0] WRAP_RECIP  = 16'd46603;

   // pi * 2^30 = 46080 * PI_INT + PI_FRAC
   localparam logic [16:0] PI_INT      = 17'd73204;
   localparam logic [14:0] PI_FRAC     = 15'd19106;
   localparam logic [28:0] RAD_ROUND   = 29'd23040;
   // ceil(2^26 / 45)
   localparam logic [20:0] DIV45_RECIP = 21'd1491309;

   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [63:0] HALF_Q30 = 64'h2000_0000;

   // One item moving down the series pipeline
   typedef struct packed {
      logic               valid;
      logic               sin_neg;
      logic               cos_neg;
      logic [31:0]        r2;
      logic [31:0]        t;
      logic [31:0]        u;
      logic signed [33:0] s_sum;
      logic signed [33:0] c_sum;
   } lane_type;

   function automatic int latency(input int terms);
      return REDUCE_STAGES + TERM_STAGES * (terms - 1) + OUT_STAGES;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/degree_sine_cosine_unit_top.sv
// Top level of the degree sine/cosine unit.
// Usage:
//   Drive req_angle_deg (signed degrees, 8 fraction bits) and raise start.
//   A transaction is taken at every clock edge with start high and busy low;
//   busy stays low, so one angle can enter in every cycle.
//   Each transaction yields one result: rsp_sine_value and rsp_cosine_value
//   (signed Q1.15, saturated at +32767) shown for exactly one cycle with
//   rsp_valid high. Results come out in input order.
// Pipeline: 8 stages reduce and fold the angle and form r and r squared,
//   each series step spends 4 stages on its multiply and constant division,
//   and 3 stages sum, apply quadrant signs and round.
// Throughput: one transaction per cycle.
// Reset: synchronous; clears all valid bits, dropping transactions in flight.
// The receiver cannot stall; results are presented once and not held.
`default_nettype none
module degree_sine_cosine_unit_top #(
   parameter int SERIES_TERMS = dscu_pkg::SERIES_TERMS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [23:0] req_angle_deg,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_sine_value,
   output logic signed [15:0]      rsp_cosine_value
);

   localparam bit LAST_ADD = (SERIES_TERMS % 2) == 1;

   dscu_pkg::lane_type lane [SERIES_TERMS];

   logic               o1_v_ff, o2_v_ff, o3_v_ff;
   logic               o1_sn_ff, o1_cn_ff;
   logic signed [33:0] o1_s_ff, o1_c_ff, o2_s_ff, o2_c_ff;
   logic signed [33:0] s_in, c_in;
   logic signed [15:0] sin_in, cos_in;
   logic signed [15:0] sin_ff, cos_ff;

   assign busy = 1'b0;

   dscu_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .angle_deg (req_angle_deg),
      .lane_out  (lane[0])
   );

   // Chain of series steps
   for (genvar k = 1; k < SERIES_TERMS; k++) begin : g_term
      dscu_term #(.K(k)) u_term (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lane[k-1]),
         .lane_out (lane[k])
      );
   end

   // Accumulate the last term with its alternating sign
   always_comb begin
      if (LAST_ADD) begin
         s_in = lane[SERIES_TERMS-1].s_sum + 34'(lane[SERIES_TERMS-1].t);
         c_in = lane[SERIES_TERMS-1].c_sum + 34'(lane[SERIES_TERMS-1].u);
      end else begin
         s_in = lane[SERIES_TERMS-1].s_sum - 34'(lane[SERIES_TERMS-1].t);
         c_in = lane[SERIES_TERMS-1].c_sum - 34'(lane[SERIES_TERMS-1].u);
      end
   end

   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] x;
      logic signed [19:0] q;
      x = 35'(v) + 35'sd16384;
      q = 20'(x >>> 15);
      if (q > 20'sd32767) begin
         return 16'sd32767;
      end else if (q < -20'sd32768) begin
         return -16'sd32768;
      end
      return 16'(q);
   endfunction

   assign sin_in = to_q15(o2_s_ff);
   assign cos_in = to_q15(o2_c_ff);

   // Advance output valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         o1_v_ff <= 1'b0;
         o2_v_ff <= 1'b0;
         o3_v_ff <= 1'b0;
      end else begin
         o1_v_ff <= lane[SERIES_TERMS-1].valid;
         o2_v_ff <= o1_v_ff;
         o3_v_ff <= o2_v_ff;
      end
   end

   // Register the final sums, apply quadrant signs, round and saturate
   always_ff @(posedge clock) begin
      o1_s_ff  <= s_in;
      o1_c_ff  <= c_in;
      o1_sn_ff <= lane[SERIES_TERMS-1].sin_neg;
      o1_cn_ff <= lane[SERIES_TERMS-1].cos_neg;
      o2_s_ff  <= o1_sn_ff ? -o1_s_ff : o1_s_ff;
      o2_c_ff  <= o1_cn_ff ? -o1_c_ff : o1_c_ff;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
   end

   assign rsp_valid        = o3_v_ff;
   assign rsp_sine_value   = sin_ff;
   assign rsp_cosine_value = cos_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dscu_reduce.sv
// Angle reduction, quadrant fold, degree-to-radian scaling and squaring.
`default_nettype none
module dscu_reduce (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic signed [23:0]  angle_deg,
   output dscu_pkg::lane_type       lane_out
);

   logic [6:0]  v_ff;
   logic [24:0] u_ff, u_in;
   logic [40:0] prod_ff, prod_in;
   logic [16:0] j_ff, j_in;
   logic [24:0] diff;
   logic [8:0]  q_est;
   logic [14:0] l_ff, l_in;
   logic        sn3_ff, cn3_ff, sn_in, cn_in;
   logic        sn4_ff, cn4_ff, sn5_ff, cn5_ff, sn6_ff, cn6_ff, sn7_ff, cn7_ff;
   logic [31:0] ai4_ff, ai5_ff;
   logic [28:0] b_ff;
   logic [39:0] zm_ff;
   logic [30:0] r6_ff, r7_ff;
   logic [61:0] rr_ff;
   dscu_pkg::lane_type lane_ff, lane_in;

   // Bias into positive range and estimate the multiple of 360 degrees
   assign u_in    = {angle_deg[23], angle_deg} + dscu_pkg::WRAP_OFFSET;
   assign prod_in = 41'(u_in) * 41'(dscu_pkg::WRAP_RECIP);

   // Take remainder, correct the estimate by one subtract
   always_comb begin
      q_est = prod_ff[40:32];
      diff  = u_ff - 25'(q_est) * 25'(dscu_pkg::UNITS_360);
      if (diff >= 25'(dscu_pkg::UNITS_360)) begin
         j_in = 17'(diff - 25'(dscu_pkg::UNITS_360));
      end else begin
         j_in = diff[16:0];
      end
   end

   // Fold into the first quadrant
   always_comb begin
      if (j_ff <= dscu_pkg::UNITS_90) begin
         l_in = j_ff[14:0];
         sn_in = 1'b0; cn_in = 1'b0;
      end else if (j_ff <= dscu_pkg::UNITS_180) begin
         l_in = 15'(dscu_pkg::UNITS_180 - j_ff);
         sn_in = 1'b0; cn_in = 1'b1;
      end else if (j_ff <= dscu_pkg::UNITS_270) begin
         l_in = 15'(j_ff - dscu_pkg::UNITS_180);
         sn_in = 1'b1; cn_in = 1'b1;
      end else begin
         l_in = 15'(dscu_pkg::UNITS_360 - j_ff);
         sn_in = 1'b1; cn_in = 1'b0;
      end
   end

   // Assemble the lane after squaring
   always_comb begin
      lane_in         = '0;
      lane_in.valid   = v_ff[6];
      lane_in.sin_neg = sn7_ff;
      lane_in.cos_neg = cn7_ff;
      lane_in.r2      = 32'((rr_ff + 62'(dscu_pkg::HALF_Q30)) >> 30);
      lane_in.t       = {1'b0, r7_ff};
      lane_in.u       = dscu_pkg::ONE_Q30;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      prod_ff <= prod_in;
      j_ff    <= j_in;
      l_ff    <= l_in;
      sn3_ff  <= sn_in;
      cn3_ff  <= cn_in;
      ai4_ff  <= 32'(l_ff) * 32'(dscu_pkg::PI_INT);
      b_ff    <= 29'(l_ff) * 29'(dscu_pkg::PI_FRAC) + dscu_pkg::RAD_ROUND;
      sn4_ff  <= sn3_ff;
      cn4_ff  <= cn3_ff;
      ai5_ff  <= ai4_ff;
      zm_ff   <= 40'(b_ff[28:10]) * 40'(dscu_pkg::DIV45_RECIP);
      sn5_ff  <= sn4_ff;
      cn5_ff  <= cn4_ff;
      r6_ff   <= 31'(ai5_ff + 32'(zm_ff[39:26]));
      sn6_ff  <= sn5_ff;
      cn6_ff  <= cn5_ff;
      rr_ff   <= 62'(r6_ff) * 62'(r6_ff);
      r7_ff   <= r6_ff;
      sn7_ff  <= sn6_ff;
      cn7_ff  <= cn6_ff;
   end

   // Hold the lane register, clearing only its valid bit on reset
   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end
   end

   assign lane_out = lane_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dscu_term.sv
// One series step: accumulate term K, then form term K+1 for sine and cosine.
`default_nettype none
module dscu_term #(
   parameter int K = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  dscu_pkg::lane_type lane_in,
   output dscu_pkg::lane_type lane_out
);

   localparam logic [9:0]  DT = 10'(2 * K * (2 * K + 1));
   localparam logic [9:0]  DU = 10'((2 * K - 1) * (2 * K));
   localparam logic [31:0] MT = 32'(64'h1_0000_0000 / DT);
   localparam logic [31:0] MU = 32'(64'h1_0000_0000 / DU);
   localparam bit          ADD_TERM = (K % 2) == 1;

   dscu_pkg::lane_type l1_ff, l1_in, l2_ff, l3_ff, l4_ff, l4_in;
   logic [63:0] pt_ff, pu_ff;
   logic [31:0] nt_ff, nu_ff, nt3_ff, nu3_ff;
   logic [63:0] mt_ff, mu_ff;
   logic [31:0] qt, qu, rt, ru;

   // Accumulate the current term with its alternating sign
   always_comb begin
      l1_in = lane_in;
      if (ADD_TERM) begin
         l1_in.s_sum = lane_in.s_sum + 34'(lane_in.t);
         l1_in.c_sum = lane_in.c_sum + 34'(lane_in.u);
      end else begin
         l1_in.s_sum = lane_in.s_sum - 34'(lane_in.t);
         l1_in.c_sum = lane_in.c_sum - 34'(lane_in.u);
      end
   end

   // Divide by the term's constant: reciprocal estimate, one-step correction
   always_comb begin
      qt = mt_ff[63:32];
      qu = mu_ff[63:32];
      rt = nt3_ff - 32'(qt * 32'(DT));
      ru = nu3_ff - 32'(qu * 32'(DU));
      l4_in   = l3_ff;
      l4_in.t = (rt >= 32'(DT)) ? qt + 32'd1 : qt;
      l4_in.u = (ru >= 32'(DU)) ? qu + 32'd1 : qu;
   end

   // Advance arithmetic
   always_ff @(posedge clock) begin
      pt_ff  <= 64'(lane_in.t) * 64'(lane_in.r2);
      pu_ff  <= 64'(lane_in.u) * 64'(lane_in.r2);
      nt_ff  <= 32'((pt_ff + dscu_pkg::HALF_Q30) >> 30) + 32'(DT / 2);
      nu_ff  <= 32'((pu_ff + dscu_pkg::HALF_Q30) >> 30) + 32'(DU / 2);
      mt_ff  <= 64'(nt_ff) * 64'(MT);
      mu_ff  <= 64'(nu_ff) * 64'(MU);
      nt3_ff <= nt_ff;
      nu3_ff <= nu_ff;
   end

   // Advance lanes; reset drops valid bits only
   always_ff @(posedge clock) begin
      l1_ff <= l1_in;
      l2_ff <= l1_ff;
      l3_ff <= l2_ff;
      l4_ff <= l4_in;
      if (reset) begin
         l1_ff.valid <= 1'b0;
         l2_ff.valid <= 1'b0;
         l3_ff.valid <= 1'b0;
         l4_ff.valid <= 1'b0;
      end
   end

   assign lane_out = l4_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dscu_checker.sv
// Port-level checks for the degree sine/cosine unit, bound to the top level.
`default_nettype none
module dscu_checker #(
   parameter int SERIES_TERMS = dscu_pkg::SERIES_TERMS
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic signed [23:0] req_angle_deg,
   input wire logic               rsp_valid,
   input wire logic signed [15:0] rsp_sine_value,
   input wire logic signed [15:0] rsp_cosine_value
);

   localparam int LAT = dscu_pkg::latency(SERIES_TERMS);

   logic accept;
   assign accept = start && !busy;

   // Never refuse a transaction
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every transaction returns after the fixed latency
   a_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("result missing");

   // No result without a transaction
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##LAT !rsp_valid)
      else $error("spurious result");

   // Zero degrees gives sine zero and saturated cosine
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_angle_deg == 24'sd0) |->
         ##LAT (rsp_sine_value == 16'sd0 && rsp_cosine_value == 16'sd32767))
      else $error("zero angle result wrong");

endmodule

bind degree_sine_cosine_unit_top dscu_checker #(.SERIES_TERMS(SERIES_TERMS)) u_dscu_checker (.*);
`default_nettype wire
